/* hdl/mad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types, sizes and codes of the motion activity detector.
// ----------------------------------------------------------------------------
package mad_pkg;

  // Ring window depth and the widths that follow from it.
  localparam int WINDOW   = 16;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 2);

  localparam int SMP_W    = 16;
  localparam int TOT_W    = SMP_W + 2;
  localparam int ACT_W    = 12;

  // Truncating divide by WINDOW*3, done as a multiply by a rounded-up
  // reciprocal that is exact for every TOT_W-bit total.
  localparam int      DIVISOR  = WINDOW * 3;
  localparam int      RECIP_L  = $clog2(DIVISOR);
  localparam int      RECIP_SH = TOT_W + RECIP_L;
  localparam int      RECIP_W  = TOT_W + 1;
  localparam longint  RECIP_LI = ((longint'(1) << RECIP_SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_LI);
  localparam int      PROD_W   = TOT_W + RECIP_W;
  localparam int      LVL_W    = PROD_W - RECIP_SH;

  localparam logic [TOT_W-1:0] LEVEL_MAX = TOT_W'((1 << ACT_W) - 1);

  // Register reset values.
  localparam logic              MODE_RST  = 1'b1;
  localparam logic [1:0]        AXIS_RST  = 2'd2;
  localparam logic [SMP_W-1:0]  THR_RST   = 16'd100;
  localparam logic [7:0]        HOLD_RST  = 8'd5;

  // One row of the gyro window: all three axes side by side.
  typedef struct packed {
    logic [SMP_W-1:0] x;
    logic [SMP_W-1:0] y;
    logic [SMP_W-1:0] z;
  } axis3_t;

  typedef enum logic [2:0] {
    REG_DETECT_MODE = 3'd0,
    REG_ACC_AXIS    = 3'd1,
    REG_ON_LOW      = 3'd2,
    REG_ON_HIGH     = 3'd3,
    REG_OFF_LOW     = 3'd4,
    REG_OFF_HIGH    = 3'd5,
    REG_GYRO_THR    = 3'd6,
    REG_OFF_HOLD    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ON   = 2'd1,
    EV_OFF  = 2'd2
  } event_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

/* hdl/mad_diff_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_diff_unit
// Shared absolute-difference accumulator, one lane for each gyro axis.
// ----------------------------------------------------------------------------
module mad_diff_unit import mad_pkg::*; (
  input  axis3_t a_i,
  input  axis3_t b_i,
  input  axis3_t acc_i,
  output axis3_t acc_o
);

  // Adds |a - b| to the running sum, modulo 2^16.
  function automatic logic [SMP_W-1:0] absdiff_add(input logic [SMP_W-1:0] a,
                                                   input logic [SMP_W-1:0] b,
                                                   input logic [SMP_W-1:0] acc);
    logic signed [SMP_W:0] diff;
    logic        [SMP_W:0] mag;
    diff = $signed({a[SMP_W-1], a}) - $signed({b[SMP_W-1], b});
    mag  = diff[SMP_W] ? (SMP_W+1)'(-diff) : diff;
    return acc + mag[SMP_W-1:0];
  endfunction

  assign acc_o.x = absdiff_add(a_i.x, b_i.x, acc_i.x);
  assign acc_o.y = absdiff_add(a_i.y, b_i.y, acc_i.y);
  assign acc_o.z = absdiff_add(a_i.z, b_i.z, acc_i.z);

endmodule

/* hdl/motion_activity_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_activity_detector_top
// Tracks an on/off activity flag from one IMU sample per beat, either by an
// accelerometer window test or by the ring-difference activity of the gyro.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  -----------------------------------
//  in       sink       in_valid_i/in_stall_o  acc_x/y/z_i, gyro_x/y/z_i
//  out      source     out_valid_o/out_stall_i event_res_o, active_o,
//                                             activity_level_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A gyro beat walks the window memory through its single read port into the
// shared difference unit, then adds the three axis sums, multiplies by the
// reciprocal and decides. An accelerometer beat goes from acceptance straight
// to the decision step. One beat is in work at a time, so a new beat is taken
// only once the last one has returned to idle. Reset clears the control state
// and the per-row valid bits, so window entries that were never written read
// as zero. A stalled result only delays the return to idle.

module motion_activity_detector_top import mad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SMP_W-1:0]  acc_x_i,
  input  logic [SMP_W-1:0]  acc_y_i,
  input  logic [SMP_W-1:0]  acc_z_i,
  input  logic [SMP_W-1:0]  gyro_x_i,
  input  logic [SMP_W-1:0]  gyro_y_i,
  input  logic [SMP_W-1:0]  gyro_z_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_res_o,
  output logic              active_o,
  output logic [ACT_W-1:0]  activity_level_o,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [SMP_W-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // --------------------------------------------------------------------------
  logic                     detect_mode_q;
  logic [1:0]               acc_axis_q;
  logic signed [SMP_W-1:0]  on_low_q, on_high_q, off_low_q, off_high_q;
  logic [SMP_W-1:0]         gyro_thr_q;
  logic [7:0]               off_hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_mode_q <= MODE_RST;
      acc_axis_q    <= AXIS_RST;
      on_low_q      <= '0;
      on_high_q     <= '0;
      off_low_q     <= '0;
      off_high_q    <= '0;
      gyro_thr_q    <= THR_RST;
      off_hold_q    <= HOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_DETECT_MODE: detect_mode_q <= cfg_data_i[0];
        REG_ACC_AXIS:    acc_axis_q    <= cfg_data_i[1:0];
        REG_ON_LOW:      on_low_q      <= cfg_data_i;
        REG_ON_HIGH:     on_high_q     <= cfg_data_i;
        REG_OFF_LOW:     off_low_q     <= cfg_data_i;
        REG_OFF_HIGH:    off_high_q    <= cfg_data_i;
        REG_GYRO_THR:    gyro_thr_q    <= cfg_data_i;
        REG_OFF_HOLD:    off_hold_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // --------------------------------------------------------------------------
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [WINDOW-1:0]        row_vld_q;
  logic                     in_acc;
  logic                     wr_en;

  logic signed [SMP_W-1:0]  acc_smp_q, acc_smp_d;
  axis3_t                   first_q, first_d;
  axis3_t                   prev_q, prev_d;
  axis3_t                   sum_q, sum_d;
  axis3_t                   diff_a;
  axis3_t                   diff_sum;
  logic [TOT_W-1:0]         total_q, total_d;
  logic [LVL_W-1:0]         level_q, level_d;
  logic [PROD_W-1:0]        prod;

  logic                     is_active_q, is_active_d;
  logic [7:0]               quiet_q, quiet_d;

  logic                     out_valid_q, out_valid_d;
  logic [1:0]               event_q, event_d;
  logic                     active_out_q, active_out_d;
  logic [ACT_W-1:0]         level_out_q, level_out_d;

  logic                     out_free;
  event_e                   ev;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && detect_mode_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Gyro window memory: one row holds all three axes. The read data is
  // registered together with the row's valid bit, so an unwritten row
  // reads as zero.
  // --------------------------------------------------------------------------
  axis3_t                   win_mem [WINDOW];
  axis3_t                   rd_row_q;
  logic                     rd_vld_q;
  axis3_t                   rd_data;
  logic [SLOT_W-1:0]        rd_addr;

  assign rd_addr = cnt_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[slot_q] <= '{x: gyro_x_i, y: gyro_y_i, z: gyro_z_i};
    end
    rd_row_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[slot_q] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[rd_addr];
    end
  end

  assign rd_data = rd_vld_q ? rd_row_q : '0;

  // The last step closes the ring with the first row against the last one.
  assign diff_a = (cnt_q == CNT_W'(WINDOW + 1)) ? first_q : rd_data;

  mad_diff_unit u_diff (
    .a_i   (diff_a),
    .b_i   (prev_q),
    .acc_i (sum_q),
    .acc_o (diff_sum)
  );

  assign prod = PROD_W'(total_q) * PROD_W'(RECIP);

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    acc_smp_d    = acc_smp_q;
    first_d      = first_q;
    prev_d       = prev_q;
    sum_d        = sum_q;
    total_d      = total_q;
    level_d      = level_q;
    is_active_d  = is_active_q;
    quiet_d      = quiet_q;
    out_valid_d  = out_valid_q && out_stall_i;
    event_d      = event_q;
    active_out_d = active_out_q;
    level_out_d  = level_out_q;
    ev           = EV_NONE;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          sum_d = '0;
          case (axis_sel_e'(acc_axis_q))
            AXIS_X:  acc_smp_d = acc_x_i;
            AXIS_Y:  acc_smp_d = acc_y_i;
            AXIS_Z:  acc_smp_d = acc_z_i;
            default: acc_smp_d = '0;
          endcase
          if (detect_mode_q) begin
            slot_d  = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_RUN: begin
        // Row cnt-1 arrives while row cnt is being read.
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          first_d = rd_data;
          prev_d  = rd_data;
        end else if (cnt_q != '0) begin
          sum_d  = diff_sum;
          prev_d = rd_data;
        end
        if (cnt_q == CNT_W'(WINDOW + 1)) begin
          state_d = ST_SUM;
        end
      end

      ST_SUM: begin
        total_d = TOT_W'(sum_q.x) + TOT_W'(sum_q.y) + TOT_W'(sum_q.z);
        state_d = ST_MUL;
      end

      ST_MUL: begin
        level_d = prod[PROD_W-1:RECIP_SH];
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          if (detect_mode_q) begin
            if (TOT_W'(level_q) > TOT_W'(gyro_thr_q)) begin
              if (!is_active_q) begin
                is_active_d = 1'b1;
                ev          = EV_ON;
              end
              quiet_d = off_hold_q;
            end else begin
              if (is_active_q && quiet_q == '0) begin
                is_active_d = 1'b0;
                ev          = EV_OFF;
              end
              if (quiet_q != '0) begin
                quiet_d = quiet_q - 8'd1;
              end
            end
            level_out_d = (TOT_W'(level_q) > LEVEL_MAX) ? ACT_W'(LEVEL_MAX)
                                                        : ACT_W'(level_q);
          end else begin
            if (acc_smp_q > on_low_q && acc_smp_q < on_high_q && !is_active_q) begin
              is_active_d = 1'b1;
              ev          = EV_ON;
            end else if (acc_smp_q <= off_high_q && acc_smp_q >= off_low_q &&
                         is_active_q) begin
              is_active_d = 1'b0;
              ev          = EV_OFF;
            end
            level_out_d = '0;
          end
          out_valid_d  = 1'b1;
          event_d      = ev;
          active_out_d = is_active_d;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      is_active_q <= 1'b0;
      quiet_q     <= HOLD_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      is_active_q <= is_active_d;
      quiet_q     <= quiet_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_smp_q    <= acc_smp_d;
    first_q      <= first_d;
    prev_q       <= prev_d;
    sum_q        <= sum_d;
    total_q      <= total_d;
    level_q      <= level_d;
    event_q      <= event_d;
    active_out_q <= active_out_d;
    level_out_q  <= level_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = event_q;
  assign active_o         = active_out_q;
  assign activity_level_o = level_out_q;

endmodule
